// ===== hdl/rk4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and saturating helpers for the rk4 orbit stepper
// no dependencies
package rk4_pkg;

   localparam int WORD_WIDTH = 48;
   localparam int FRAC_BITS  = 32;
   localparam int CFG_W      = 47;
   localparam int CNT_W      = 20;
   localparam int CSR_IDX_W  = 2;
   // exact weighted sum k1 + 2*k2 + 2*k3 + k4
   localparam int SUM_W      = WORD_WIDTH + 3;
   localparam int CMP_W      = (CFG_W > WORD_WIDTH) ? CFG_W : WORD_WIDTH;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic [CFG_W-1:0]             cfg_type;
   typedef logic [CNT_W-1:0]             cnt_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic [CSR_IDX_W-1:0]         csr_idx_type;

   localparam csr_idx_type CSR_STEP_SIZE  = csr_idx_type'(0);
   localparam csr_idx_type CSR_STIFFNESS  = csr_idx_type'(1);
   localparam csr_idx_type CSR_STEP_COUNT = csr_idx_type'(2);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam cfg_type STEP_SIZE_RST  = cfg_type'(64'd4294967);
   localparam cfg_type STIFFNESS_RST  = cfg_type'(64'd169560256590);
   localparam cnt_type STEP_COUNT_RST = cnt_type'(32'd1000);

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic     start;
      logic     negate;
      word_type a;
      word_type b;
   } mul_req_type;

   function automatic word_type sat_add(word_type a, word_type b);
      logic signed [WORD_WIDTH:0] s;
      s = $signed({a[WORD_WIDTH-1], a}) + $signed({b[WORD_WIDTH-1], b});
      if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
         return s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_WIDTH-1:0];
   endfunction

   // unsigned register value clamped to the largest positive word
   function automatic word_type clamp_cfg(cfg_type u);
      logic [CMP_W-1:0] ue;
      logic [CMP_W-1:0] lim;
      ue  = CMP_W'(u);
      lim = CMP_W'(WORD_MAX);
      if (ue > lim) begin
         return WORD_MAX;
      end
      return ue[WORD_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/rk4_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channel interfaces: step requests, results and register writes
// depends on rk4_pkg
interface rk4_req_if import rk4_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     cmd;
   word_type start_pos;
   word_type start_vel;

   modport source (output valid, output cmd, output start_pos, output start_vel, input ready);
   modport sink   (input valid, input cmd, input start_pos, input start_vel, output ready);
endinterface

interface rk4_rsp_if import rk4_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type position;
   word_type velocity;
   cnt_type  step_index;
   logic     last_step;

   modport source (output valid, output position, output velocity, output step_index,
                   output last_step, input ready);
   modport sink   (input valid, input position, input velocity, input step_index,
                   input last_step, output ready);
endinterface

interface rk4_csr_if import rk4_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   cfg_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/rk4_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared fixed-point multiplier: two half-width partial products, round, saturate,
// optional saturating negate; depends on rk4_pkg
module rk4_mul import rk4_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type req,
   output word_type         res,
   output logic             done
);

   localparam int LO_W   = WORD_WIDTH / 2;
   localparam int HI_W   = WORD_WIDTH - LO_W;
   localparam int MOP_W  = HI_W + 1;
   localparam int PP_W   = WORD_WIDTH + MOP_W;
   localparam int PROD_W = 2 * WORD_WIDTH;

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_LO   = 3'd1;
   localparam logic [2:0] M_HI   = 3'd2;
   localparam logic [2:0] M_ACC  = 3'd3;
   localparam logic [2:0] M_RND  = 3'd4;
   localparam logic [2:0] M_NEG  = 3'd5;

   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] WIDE_MAX = PROD_W'(WORD_MAX);
   localparam logic signed [PROD_W-1:0] WIDE_MIN = PROD_W'(WORD_MIN);

   logic [2:0]               state_ff, state_in;
   word_type                 a_ff, a_in;
   word_type                 b_ff, b_in;
   logic                     neg_ff, neg_in;
   logic signed [PP_W-1:0]   pp_ff, pp_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   word_type                 rnd_ff, rnd_in;
   word_type                 res_ff, res_in;
   logic                     done_ff, done_in;

   logic signed [MOP_W-1:0]  mop;
   logic signed [PROD_W-1:0] rsum;
   logic signed [PROD_W-1:0] shifted;

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      neg_in   = neg_ff;
      pp_in    = pp_ff;
      acc_in   = acc_ff;
      rnd_in   = rnd_ff;
      res_in   = res_ff;
      done_in  = 1'b0;

      // low half of b is unsigned, high half carries the sign
      if (state_ff == M_LO) begin
         mop = $signed({{(MOP_W-LO_W){1'b0}}, b_ff[LO_W-1:0]});
      end else begin
         mop = $signed({b_ff[WORD_WIDTH-1], b_ff[WORD_WIDTH-1:LO_W]});
      end

      rsum    = acc_ff + RND_HALF;
      shifted = rsum >>> FRAC_BITS;

      case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               a_in     = req.a;
               b_in     = req.b;
               neg_in   = req.negate;
               state_in = M_LO;
            end
         end
         M_LO: begin
            pp_in    = a_ff * mop;
            state_in = M_HI;
         end
         M_HI: begin
            acc_in   = PROD_W'(pp_ff);
            pp_in    = a_ff * mop;
            state_in = M_ACC;
         end
         M_ACC: begin
            acc_in   = acc_ff + (PROD_W'(pp_ff) <<< LO_W);
            state_in = M_RND;
         end
         M_RND: begin
            if (shifted > WIDE_MAX) begin
               rnd_in = WORD_MAX;
            end else if (shifted < WIDE_MIN) begin
               rnd_in = WORD_MIN;
            end else begin
               rnd_in = shifted[WORD_WIDTH-1:0];
            end
            state_in = M_NEG;
         end
         M_NEG: begin
            if (!neg_ff) begin
               res_in = rnd_ff;
            end else if (rnd_ff == WORD_MIN) begin
               res_in = WORD_MAX;
            end else begin
               res_in = -rnd_ff;
            end
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      neg_ff <= neg_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
      rnd_ff <= rnd_in;
      res_ff <= res_in;
   end

   assign res  = res_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// ===== hdl/rk4_div3.sv =====
`timescale 1ns / 1ps
`default_nettype none
// weighted-sum divide by six with round half up, eight quotient bits per cycle,
// saturated to the word; depends on rk4_pkg
module rk4_div3 import rk4_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sum_type sum,
   output word_type     quot,
   output logic         done
);

   localparam int MIX_W = WORD_WIDTH + 3;
   localparam int NDIG  = (MIX_W + 7) / 8;
   localparam int DIG_W = NDIG * 8;
   localparam int EXT_W = WORD_WIDTH + 4;
   localparam int DC_W  = $clog2(NDIG + 1);
   localparam int QV_W  = MIX_W + 1;

   // (s + 3 + 6*2^W) / 2 is never negative; the 2^W offset comes back out at the end
   localparam logic [EXT_W-1:0] BIAS = (EXT_W'(6) << WORD_WIDTH) + EXT_W'(3);
   localparam logic signed [QV_W-1:0] OFFSET   = QV_W'(1) << WORD_WIDTH;
   localparam logic signed [QV_W-1:0] WIDE_MAX = QV_W'(WORD_MAX);
   localparam logic signed [QV_W-1:0] WIDE_MIN = QV_W'(WORD_MIN);
   localparam logic [DC_W-1:0] DIG_LAST = DC_W'(NDIG - 1);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_RUN  = 2'd1;
   localparam logic [1:0] D_FIN  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [DC_W-1:0]  cnt_ff, cnt_in;
   logic [DIG_W-1:0] sh_ff, sh_in;
   logic [DIG_W-1:0] q_ff, q_in;
   logic [1:0]       rem_ff, rem_in;
   word_type         quot_ff, quot_in;
   logic             done_ff, done_in;

   logic [EXT_W-1:0]        biased;
   logic [7:0]              digit;
   logic [7:0]              qbits;
   logic [2:0]              r;
   logic signed [QV_W-1:0]  qv;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sh_in    = sh_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;

      biased = EXT_W'(sum) + BIAS;

      // eight restoring steps of the remainder mod 3
      digit = sh_ff[DIG_W-1 -: 8];
      qbits = '0;
      r     = {1'b0, rem_ff};
      for (int i = 7; i >= 0; i--) begin
         r = {r[1:0], digit[i]};
         if (r >= 3'd3) begin
            r        = r - 3'd3;
            qbits[i] = 1'b1;
         end
      end

      qv = $signed({1'b0, q_ff[MIX_W-1:0]}) - OFFSET;

      case (state_ff)
         D_IDLE: begin
            if (start) begin
               sh_in    = DIG_W'(biased[EXT_W-1:1]);
               q_in     = '0;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            sh_in  = sh_ff << 8;
            q_in   = {q_ff[DIG_W-9:0], qbits};
            rem_in = r[1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIG_LAST) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            if (qv > WIDE_MAX) begin
               quot_in = WORD_MAX;
            end else if (qv < WIDE_MIN) begin
               quot_in = WORD_MIN;
            end else begin
               quot_in = qv[WORD_WIDTH-1:0];
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      sh_ff   <= sh_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// ===== hdl/rk4_harmonic_orbit_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// rk4 integrator for x'' = -c*x, one item at a time under a step sequencer
// a load beat writes position and velocity and goes straight to the response; a step
// beat runs nine products on the one shared multiplier, the operand sums between them,
// and a divide by six for both weighted sums
// one item at a time: req ready only while the sequencer is idle
// reset: position, velocity and step counter clear, registers take their defaults
// depends on rk4_pkg, rk4_if, rk4_mul, rk4_div3
module rk4_harmonic_orbit_step import rk4_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   rk4_req_if.sink   req_bus,
   rk4_rsp_if.source rsp_bus,
   rk4_csr_if.sink   csr_bus
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_G    = 4'd1;
   localparam logic [3:0] ST_MP   = 4'd2;
   localparam logic [3:0] ST_KP   = 4'd3;
   localparam logic [3:0] ST_KV   = 4'd4;
   localparam logic [3:0] ST_OPS  = 4'd5;
   localparam logic [3:0] ST_DIV  = 4'd6;
   localparam logic [3:0] ST_DW   = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   localparam logic [1:0] STAGE_FIRST = 2'd0;
   localparam logic [1:0] STAGE_LAST  = 2'd3;

   logic [3:0] state_ff, state_in;
   logic [1:0] stage_ff, stage_in;

   cfg_type step_size_ff, step_size_in;
   cfg_type stiffness_ff, stiffness_in;
   cnt_type step_count_ff, step_count_in;

   word_type pos_ff, pos_in;
   word_type vel_ff, vel_in;
   cnt_type  cnt_ff, cnt_in;

   word_type h_ff, h_in;
   word_type g_ff, g_in;
   word_type kp_ff, kp_in;
   word_type kv_ff, kv_in;
   word_type opp_ff, opp_in;
   word_type opx_ff, opx_in;
   sum_type  sump_ff, sump_in;
   sum_type  sumv_ff, sumv_in;

   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_pos_ff, rsp_pos_in;
   word_type rsp_vel_ff, rsp_vel_in;
   cnt_type  rsp_idx_ff, rsp_idx_in;
   logic     rsp_last_ff, rsp_last_in;

   mul_req_type mul_req;
   word_type    mul_res;
   logic        mul_done;
   logic        div_start;
   word_type    quot_p, quot_v;
   logic        done_p, done_v;

   logic     req_take;
   logic     dbl;
   sum_type  res_ext;
   sum_type  res_w;
   word_type dp_term, dx_term;

   rk4_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .res   (mul_res),
      .done  (mul_done)
   );

   rk4_div3 u_div_p (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (sump_ff),
      .quot  (quot_p),
      .done  (done_p)
   );

   rk4_div3 u_div_v (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (sumv_ff),
      .quot  (quot_v),
      .done  (done_v)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign div_start     = (state_ff == ST_DIV);

   // register writes
   always_comb begin
      step_size_in  = step_size_ff;
      stiffness_in  = stiffness_ff;
      step_count_in = step_count_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_STEP_SIZE:  step_size_in  = csr_bus.data;
            CSR_STIFFNESS:  stiffness_in  = csr_bus.data;
            CSR_STEP_COUNT: step_count_in = csr_bus.data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      pos_in   = pos_ff;
      vel_in   = vel_ff;
      cnt_in   = cnt_ff;
      h_in     = h_ff;
      g_in     = g_ff;
      kp_in    = kp_ff;
      kv_in    = kv_ff;
      opp_in   = opp_ff;
      opx_in   = opx_ff;
      sump_in  = sump_ff;
      sumv_in  = sumv_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      mul_req = '0;

      // k2 and k3 count twice in the weighted sum
      dbl     = (stage_ff != STAGE_FIRST) && (stage_ff != STAGE_LAST);
      res_ext = SUM_W'(mul_res);
      res_w   = dbl ? (res_ext <<< 1) : res_ext;

      dp_term = (stage_ff == STAGE_LAST) ? kv_ff : (kv_ff >>> 1);
      dx_term = (stage_ff == STAGE_LAST) ? kp_ff : (kp_ff >>> 1);

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_bus.cmd == CMD_LOAD) begin
                  pos_in   = req_bus.start_pos;
                  vel_in   = req_bus.start_vel;
                  cnt_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  h_in           = clamp_cfg(step_size_ff);
                  mul_req.start  = 1'b1;
                  mul_req.a      = clamp_cfg(step_size_ff);
                  mul_req.b      = clamp_cfg(stiffness_ff);
                  state_in       = ST_G;
               end
            end
         end
         ST_G: begin
            if (mul_done) begin
               g_in     = mul_res;
               opp_in   = vel_ff;
               opx_in   = pos_ff;
               stage_in = STAGE_FIRST;
               sump_in  = '0;
               sumv_in  = '0;
               state_in = ST_MP;
            end
         end
         ST_MP: begin
            mul_req.start = 1'b1;
            mul_req.a     = h_ff;
            mul_req.b     = opp_ff;
            state_in      = ST_KP;
         end
         ST_KP: begin
            if (mul_done) begin
               kp_in          = mul_res;
               sump_in        = sump_ff + res_w;
               mul_req.start  = 1'b1;
               mul_req.negate = 1'b1;
               mul_req.a      = g_ff;
               mul_req.b      = opx_ff;
               state_in       = ST_KV;
            end
         end
         ST_KV: begin
            if (mul_done) begin
               kv_in   = mul_res;
               sumv_in = sumv_ff + res_w;
               if (stage_ff == STAGE_LAST) begin
                  state_in = ST_DIV;
               end else begin
                  stage_in = stage_ff + 1'b1;
                  state_in = ST_OPS;
               end
            end
         end
         ST_OPS: begin
            // both operands from the previous pair, full k on the last stage
            opp_in   = sat_add(vel_ff, dp_term);
            opx_in   = sat_add(pos_ff, dx_term);
            state_in = ST_MP;
         end
         ST_DIV: begin
            state_in = ST_DW;
         end
         ST_DW: begin
            if (done_p && done_v) begin
               pos_in   = sat_add(pos_ff, quot_p);
               vel_in   = sat_add(vel_ff, quot_v);
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_vel_in   = vel_ff;
               rsp_idx_in   = cnt_ff;
               rsp_last_in  = (cnt_ff == step_count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         stage_ff      <= STAGE_FIRST;
         step_size_ff  <= STEP_SIZE_RST;
         stiffness_ff  <= STIFFNESS_RST;
         step_count_ff <= STEP_COUNT_RST;
         pos_ff        <= '0;
         vel_ff        <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         stage_ff      <= stage_in;
         step_size_ff  <= step_size_in;
         stiffness_ff  <= stiffness_in;
         step_count_ff <= step_count_in;
         pos_ff        <= pos_in;
         vel_ff        <= vel_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      h_ff        <= h_in;
      g_ff        <= g_in;
      kp_ff       <= kp_in;
      kv_ff       <= kv_in;
      opp_ff      <= opp_in;
      opx_ff      <= opx_in;
      sump_ff     <= sump_in;
      sumv_ff     <= sumv_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.position   = rsp_pos_ff;
   assign rsp_bus.velocity   = rsp_vel_ff;
   assign rsp_bus.step_index = rsp_idx_ff;
   assign rsp_bus.last_step  = rsp_last_ff;

endmodule
`default_nettype wire
